### rtl/sccda_pkg.sv
// Shared types, codes and constants of the seconds clock with countdown alarm.
package sccda_pkg;

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_KEY  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    KEY_CONFIRM    = 3'd1,
    KEY_SET_ALARM  = 3'd2,
    KEY_MODE       = 3'd3,
    KEY_ADD_SECOND = 3'd4,
    KEY_ADD_MINUTE = 3'd5,
    KEY_ADD_HOUR   = 3'd6
  } key_t;

  typedef enum logic [1:0] {
    PHASE_IDLE    = 2'd0,
    PHASE_SETTING = 2'd1,
    PHASE_ARMED   = 2'd2
  } phase_t;

  typedef enum logic {
    REG_TICKS_PER_SECOND = 1'b0,
    REG_ALARM_DEFAULT    = 1'b1
  } cfg_reg_t;

  localparam int unsigned SEC_PER_HOUR   = 3600;
  localparam int unsigned SEC_PER_MINUTE = 60;
  localparam int unsigned DIGIT_BASE     = 10;

  localparam logic [7:0]  TICKS_RESET = 8'd20;
  localparam logic [15:0] ALARM_RESET = 16'd5;

  // Temperature slot covers the last two seconds of every ten.
  localparam logic [3:0] TEMP_SLOT_FIRST = 4'd8;

  // Remainder of a value below one hour, and rest / 60 as (rest >> 2) / 15.
  localparam int         REST_W      = 12;
  localparam int         MIN_PROD_W  = 21;
  localparam logic [10:0] DIV60_MULT = 11'd1093;
  localparam int         DIV60_SHIFT = 14;

  // v / 10 for v below 64 as (v >> 1) * 52 >> 8.
  localparam logic [5:0] DIV10_MULT = 6'd52;

  typedef struct packed {
    logic [2:0] tens;
    logic [3:0] ones;
  } digits_t;

  function automatic digits_t split_digits(input logic [5:0] value);
    logic [10:0] prod;
    logic [2:0]  tens;
    logic [5:0]  rem;
    digits_t     d;
    prod   = 11'(value[5:1]) * 11'(DIV10_MULT);
    tens   = prod[10:8];
    rem    = value - 6'(tens) * 6'(DIGIT_BASE);
    d.tens = tens;
    d.ones = rem[3:0];
    return d;
  endfunction

endpackage

### rtl/seconds_clock_with_countdown_alarm.sv
// Top level of the seconds clock with countdown alarm: state update and digit pipeline.
//
// Every accepted input beat, a timer tick or a key event, updates the clock state in
// the cycle it is accepted and yields exactly one result beat. The block takes one
// beat per clock cycle unless a stalled output has backed up every stage; the result
// leaves through a six-stage pipeline whose stages each hold their beat while the
// next one is full, so the input side keeps accepting while a finished result waits
// on the output, until every stage is full. The digit conversion fills the stages:
// the shown value and the elapsed count are split into hours, minutes and seconds by
// reciprocal multiplications. The prescaler steps a second when ticks_per_second
// ticks have been counted; a setting of zero gives one second every 256 ticks.
// Configuration writes are taken at once and are meant for idle times only; a new
// alarm_default is used at the next alarm fire. There is no clearing pass after reset.
module seconds_clock_with_countdown_alarm #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        operation,
  input  logic [2:0]  key_code,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        hour_tens,
  output logic [3:0]  hour_ones,
  output logic [2:0]  minute_tens,
  output logic [3:0]  minute_ones,
  output logic [2:0]  second_tens,
  output logic [3:0]  second_ones,
  output logic        display_mode,
  output logic [1:0]  alarm_phase,
  output logic        temperature_slot,
  output logic        alarm_fire,
  output logic [4:0]  chime_hours
);
  import sccda_pkg::*;

  localparam int CW = COUNT_WIDTH;
  // Hours of a CW-bit second count fit in CW-11 bits, since 3600 exceeds 2048.
  localparam int HW = CW - 11;

  // x / 3600 is computed as (x >> 4) / 225 with a rounded-up reciprocal that is
  // exact for every (CW-4)-bit operand.
  localparam int P3W = 2 * CW - 7;
  localparam logic [CW-4:0] M3600 = (CW - 3)'(((64'd1 << (CW + 4)) + 64'd224) / 64'd225);
  // Elapsed / 10 as (x >> 1) / 5.
  localparam int PTW = 2 * CW - 1;
  localparam logic [CW-1:0] M10E = CW'(((64'd1 << (CW + 2)) + 64'd4) / 64'd5);
  // Hours / 10 as (h >> 1) / 5.
  localparam int PHW = 2 * HW - 1;
  localparam logic [HW-1:0] M10H = HW'(((64'd1 << (HW + 2)) + 64'd4) / 64'd5);

  typedef struct packed {
    logic [CW-1:0] shown;
    logic [CW-1:0] elapsed;
    logic          step;
    logic          fire;
    logic          mode;
    phase_t        phase;
    logic          slot_en;
  } s1_t;

  typedef struct packed {
    logic [P3W-1:0] shown_prod;
    logic [P3W-1:0] elapsed_prod;
    logic [PTW-1:0] tenth_prod;
    logic [CW-1:0]  shown;
    logic [CW-1:0]  elapsed;
    logic           step;
    logic           fire;
    logic           mode;
    phase_t         phase;
    logic           slot_en;
  } s2_t;

  typedef struct packed {
    logic [HW-1:0]     hours;
    logic [REST_W-1:0] rest;
    logic [4:0]        chime;
    logic              slot;
    logic              fire;
    logic              mode;
    phase_t            phase;
  } s3_t;

  typedef struct packed {
    logic [PHW-1:0]        hour_prod;
    logic [MIN_PROD_W-1:0] minute_prod;
    logic [HW-1:0]         hours;
    logic [REST_W-1:0]     rest;
    logic [4:0]            chime;
    logic                  slot;
    logic                  fire;
    logic                  mode;
    phase_t                phase;
  } s4_t;

  typedef struct packed {
    logic       hour_tens;
    logic [3:0] hour_ones;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] chime;
    logic       slot;
    logic       fire;
    logic       mode;
    phase_t     phase;
  } s5_t;

  typedef struct packed {
    logic       hour_tens;
    logic [3:0] hour_ones;
    digits_t    minute;
    digits_t    second;
    logic [4:0] chime;
    logic       slot;
    logic       fire;
    logic       mode;
    phase_t     phase;
  } s6_t;

  // Configuration registers.
  logic [7:0]  ticks_per_second;
  logic [15:0] alarm_default;

  // Clock state and its next values.
  logic [7:0]    tick_prescale, tick_prescale_next;
  logic [CW-1:0] elapsed_seconds, elapsed_seconds_next;
  logic [CW-1:0] alarm_seconds, alarm_seconds_next;
  phase_t        alarm_phase_reg, alarm_phase_next;
  logic          mode_flag, mode_flag_next;

  logic [7:0]    prescale_inc;
  logic [CW-1:0] add_amount;
  logic          second_step;
  logic          fire_now;
  logic          in_accept;

  // Pipeline stage registers, valid bits and the ready chain.
  logic [6:1] stage_valid;
  logic [6:1] stage_ready;
  s1_t s1, s1_next;
  s2_t s2, s2_next;
  s3_t s3, s3_next;
  s4_t s4, s4_next;
  s5_t s5, s5_next;
  s6_t s6, s6_next;

  // Stage 3 and stage 5 intermediates.
  logic [HW-1:0]     hours_shown;
  logic [HW-1:0]     hours_elapsed;
  logic [CW-4:0]     tenth_quot;
  logic [CW-1:0]     rest_full;
  logic [CW-1:0]     elapsed_rem;
  logic [CW-1:0]     tenth_rem;
  logic [HW-4:0]     hour_quot;
  logic [HW-1:0]     hour_rem;
  logic [REST_W-1:0] second_full;

  // ---------------------------------------------------------------------------
  // Configuration port.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TICKS_RESET;
      alarm_default    <= ALARM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TICKS_PER_SECOND: ticks_per_second <= cfg_data[7:0];
        REG_ALARM_DEFAULT:    alarm_default    <= cfg_data;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake. Each stage loads when it is empty or its successor moves on.
  // ---------------------------------------------------------------------------
  assign stage_ready[6] = !stage_valid[6] || out_ready;
  assign stage_ready[5] = !stage_valid[5] || stage_ready[6];
  assign stage_ready[4] = !stage_valid[4] || stage_ready[5];
  assign stage_ready[3] = !stage_valid[3] || stage_ready[4];
  assign stage_ready[2] = !stage_valid[2] || stage_ready[3];
  assign stage_ready[1] = !stage_valid[1] || stage_ready[2];

  assign in_ready  = stage_ready[1];
  assign in_accept = in_valid && stage_ready[1];
  assign out_valid = stage_valid[6];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (stage_ready[1]) stage_valid[1] <= in_valid;
      if (stage_ready[2]) stage_valid[2] <= stage_valid[1];
      if (stage_ready[3]) stage_valid[3] <= stage_valid[2];
      if (stage_ready[4]) stage_valid[4] <= stage_valid[3];
      if (stage_ready[5]) stage_valid[5] <= stage_valid[4];
      if (stage_ready[6]) stage_valid[6] <= stage_valid[5];
    end
  end

  // ---------------------------------------------------------------------------
  // State update for the accepted beat. A tick advances the prescaler and may
  // make a second step and count an armed alarm down; a key event adds time to
  // the alarm while it is being set and to the clock otherwise, or changes mode
  // or alarm phase. An armed alarm at zero after the update fires and reloads.
  // ---------------------------------------------------------------------------
  always_comb begin
    tick_prescale_next   = tick_prescale;
    elapsed_seconds_next = elapsed_seconds;
    alarm_seconds_next   = alarm_seconds;
    alarm_phase_next     = alarm_phase_reg;
    mode_flag_next       = mode_flag;
    add_amount           = '0;
    second_step          = 1'b0;
    fire_now             = 1'b0;
    prescale_inc         = tick_prescale + 8'd1;

    if (op_t'(operation) == OP_TICK) begin
      if (prescale_inc == ticks_per_second) begin
        tick_prescale_next   = '0;
        elapsed_seconds_next = elapsed_seconds + CW'(1);
        second_step          = 1'b1;
        if (alarm_phase_reg == PHASE_ARMED) begin
          alarm_seconds_next = alarm_seconds - CW'(1);
        end
      end else begin
        tick_prescale_next = prescale_inc;
      end
    end else begin
      unique case (key_t'(key_code))
        KEY_ADD_HOUR:   add_amount = CW'(SEC_PER_HOUR);
        KEY_ADD_MINUTE: add_amount = CW'(SEC_PER_MINUTE);
        KEY_ADD_SECOND: add_amount = CW'(1);
        KEY_MODE:       mode_flag_next = !mode_flag;
        KEY_SET_ALARM:  alarm_phase_next = PHASE_SETTING;
        KEY_CONFIRM:    alarm_phase_next = PHASE_ARMED;
        default: ;
      endcase
      if (alarm_phase_next == PHASE_SETTING) begin
        alarm_seconds_next = alarm_seconds + add_amount;
      end else begin
        elapsed_seconds_next = elapsed_seconds + add_amount;
      end
    end

    if (alarm_phase_next == PHASE_ARMED && alarm_seconds_next == '0) begin
      fire_now           = 1'b1;
      alarm_phase_next   = PHASE_IDLE;
      alarm_seconds_next = CW'(alarm_default);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_prescale   <= '0;
      elapsed_seconds <= '0;
      alarm_seconds   <= CW'(ALARM_RESET);
      alarm_phase_reg <= PHASE_IDLE;
      mode_flag       <= 1'b0;
    end else if (in_accept) begin
      tick_prescale   <= tick_prescale_next;
      elapsed_seconds <= elapsed_seconds_next;
      alarm_seconds   <= alarm_seconds_next;
      alarm_phase_reg <= alarm_phase_next;
      mode_flag       <= mode_flag_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: the value to show and the flags of the beat. The alarm value is
  // shown only in seven-segment mode while it is being set.
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_next.elapsed = elapsed_seconds_next;
    s1_next.shown   = (!mode_flag_next && alarm_phase_next == PHASE_SETTING)
                      ? alarm_seconds_next : elapsed_seconds_next;
    s1_next.step    = second_step;
    s1_next.fire    = fire_now;
    s1_next.mode    = mode_flag_next;
    s1_next.phase   = alarm_phase_next;
    s1_next.slot_en = !mode_flag_next && alarm_phase_next != PHASE_SETTING;
  end

  // Stage 2: reciprocal products for the hour split and the last decimal digit.
  always_comb begin
    s2_next.shown_prod   = P3W'(s1.shown[CW-1:4]) * P3W'(M3600);
    s2_next.elapsed_prod = P3W'(s1.elapsed[CW-1:4]) * P3W'(M3600);
    s2_next.tenth_prod   = PTW'(s1.elapsed[CW-1:1]) * PTW'(M10E);
    s2_next.shown        = s1.shown;
    s2_next.elapsed      = s1.elapsed;
    s2_next.step         = s1.step;
    s2_next.fire         = s1.fire;
    s2_next.mode         = s1.mode;
    s2_next.phase        = s1.phase;
    s2_next.slot_en      = s1.slot_en;
  end

  // Stage 3: quotients and remainders. A chime is due when a second step lands
  // on a whole hour of the elapsed count.
  always_comb begin
    hours_shown   = s2.shown_prod[P3W-1 -: HW];
    hours_elapsed = s2.elapsed_prod[P3W-1 -: HW];
    tenth_quot    = s2.tenth_prod[PTW-1 -: (CW - 3)];
    rest_full     = s2.shown - CW'(hours_shown) * CW'(SEC_PER_HOUR);
    elapsed_rem   = s2.elapsed - CW'(hours_elapsed) * CW'(SEC_PER_HOUR);
    tenth_rem     = s2.elapsed - CW'(tenth_quot) * CW'(DIGIT_BASE);

    s3_next.hours = hours_shown;
    s3_next.rest  = rest_full[REST_W-1:0];
    s3_next.chime = (s2.step && elapsed_rem == '0) ? hours_elapsed[4:0] : 5'd0;
    s3_next.slot  = s2.slot_en && (tenth_rem[3:0] >= TEMP_SLOT_FIRST);
    s3_next.fire  = s2.fire;
    s3_next.mode  = s2.mode;
    s3_next.phase = s2.phase;
  end

  // Stage 4: products for hours / 10 and rest / 60.
  always_comb begin
    s4_next.hour_prod   = PHW'(s3.hours[HW-1:1]) * PHW'(M10H);
    s4_next.minute_prod = MIN_PROD_W'(s3.rest[REST_W-1:2]) * MIN_PROD_W'(DIV60_MULT);
    s4_next.hours       = s3.hours;
    s4_next.rest        = s3.rest;
    s4_next.chime       = s3.chime;
    s4_next.slot        = s3.slot;
    s4_next.fire        = s3.fire;
    s4_next.mode        = s3.mode;
    s4_next.phase       = s3.phase;
  end

  // Stage 5: hour digits, minutes and seconds.
  always_comb begin
    hour_quot   = s4.hour_prod[PHW-1 -: (HW - 3)];
    hour_rem    = s4.hours - HW'(hour_quot) * HW'(DIGIT_BASE);
    s5_next.minutes = s4.minute_prod[DIV60_SHIFT +: 6];
    second_full = s4.rest - REST_W'(s5_next.minutes) * REST_W'(SEC_PER_MINUTE);

    s5_next.hour_tens = hour_quot[0];
    s5_next.hour_ones = hour_rem[3:0];
    s5_next.seconds   = second_full[5:0];
    s5_next.chime     = s4.chime;
    s5_next.slot      = s4.slot;
    s5_next.fire      = s4.fire;
    s5_next.mode      = s4.mode;
    s5_next.phase     = s4.phase;
  end

  // Stage 6: output register with the minute and second digits.
  always_comb begin
    s6_next.hour_tens = s5.hour_tens;
    s6_next.hour_ones = s5.hour_ones;
    s6_next.minute    = split_digits(s5.minutes);
    s6_next.second    = split_digits(s5.seconds);
    s6_next.chime     = s5.chime;
    s6_next.slot      = s5.slot;
    s6_next.fire      = s5.fire;
    s6_next.mode      = s5.mode;
    s6_next.phase     = s5.phase;
  end

  always_ff @(posedge clk) begin
    if (stage_ready[1] && in_valid)       s1 <= s1_next;
    if (stage_ready[2] && stage_valid[1]) s2 <= s2_next;
    if (stage_ready[3] && stage_valid[2]) s3 <= s3_next;
    if (stage_ready[4] && stage_valid[3]) s4 <= s4_next;
    if (stage_ready[5] && stage_valid[4]) s5 <= s5_next;
    if (stage_ready[6] && stage_valid[5]) s6 <= s6_next;
  end

  assign hour_tens        = s6.hour_tens;
  assign hour_ones        = s6.hour_ones;
  assign minute_tens      = s6.minute.tens;
  assign minute_ones      = s6.minute.ones;
  assign second_tens      = s6.second.tens;
  assign second_ones      = s6.second.ones;
  assign display_mode     = s6.mode;
  assign alarm_phase      = s6.phase;
  assign temperature_slot = s6.slot;
  assign alarm_fire       = s6.fire;
  assign chime_hours      = s6.chime;

endmodule

### rtl/sccda_checker.sv
// Port-level assertions for the seconds clock with countdown alarm, and their bind.
module sccda_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       hour_tens,
  input logic [3:0] hour_ones,
  input logic [2:0] minute_tens,
  input logic [3:0] minute_ones,
  input logic [2:0] second_tens,
  input logic [3:0] second_ones,
  input logic       display_mode,
  input logic [1:0] alarm_phase,
  input logic       temperature_slot,
  input logic       alarm_fire,
  input logic [4:0] chime_hours
);
  import sccda_pkg::*;

  // A fired alarm is back in idle on the same beat.
  a_fire_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && alarm_fire |-> alarm_phase == PHASE_IDLE)
    else $error("alarm fired but phase is not idle");

  // The temperature slot never shows while the alarm is being set or in LCD mode.
  a_slot_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && temperature_slot |-> !display_mode && alarm_phase != PHASE_SETTING)
    else $error("temperature slot outside seven-segment clock display");

  // A chime lands on a whole hour of the shown clock value.
  a_chime_hour: assert property (@(posedge clk) disable iff (rst)
    out_valid && chime_hours != 5'd0 && (display_mode || alarm_phase != PHASE_SETTING)
    |-> minute_tens == 3'd0 && minute_ones == 4'd0 &&
        second_tens == 3'd0 && second_ones == 4'd0)
    else $error("chime on a value that is not a whole hour");

  // Digit split stays in decimal range.
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> minute_tens <= 3'd5 && minute_ones <= 4'd9 &&
                  second_tens <= 3'd5 && second_ones <= 4'd9 && hour_ones <= 4'd9)
    else $error("digit out of decimal range");

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chime_hours) && $stable(alarm_fire) &&
                                $stable(second_ones) && $stable(hour_tens))
    else $error("result beat changed while stalled");

endmodule

bind seconds_clock_with_countdown_alarm sccda_checker u_sccda_checker (.*);
